FILE: src/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("check failed");

`endif

FILE: src/ehash_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ehash_pkg;
   localparam int MAX_GLOBAL_DEPTH = 8;
   localparam int BUCKET_SLOTS     = 16;
   localparam int DIR_W            = MAX_GLOBAL_DEPTH;
   localparam int DIR_ENTRIES      = 1 << DIR_W;
   localparam int BKT_W            = MAX_GLOBAL_DEPTH;
   localparam int NFB_W            = BKT_W + 1;
   localparam int SLOT_W           = $clog2(BUCKET_SLOTS);
   localparam int FILL_W           = $clog2(BUCKET_SLOTS + 1);
   localparam int DEPTH_W          = $clog2(MAX_GLOBAL_DEPTH + 1);
   localparam int SLOT_ADDR_W      = BKT_W + SLOT_W;
   localparam int SLOT_TOTAL       = 1 << SLOT_ADDR_W;
   localparam int COUNT_W          = 13;
   localparam int KEY_W            = 64;
   localparam int HASH_W           = 32;
   localparam int MIX_SHIFT        = 33;
   localparam logic [63:0] MIX_C1  = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2  = 64'hc4ceb9fe1a85ec53;

   typedef enum logic [1:0] {
      REQ_LOOKUP  = 2'd0,
      REQ_INSERT  = 2'd1,
      REQ_REMOVE  = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [31:0]      page;
      logic [15:0]      slot;
   } entry_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] ld;
      logic [FILL_W-1:0]  fill;
   } meta_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] hash;
   } mix_out_type;
endpackage
`default_nettype wire

FILE: src/ehash_mix.sv
`timescale 1ns / 1ps
`default_nettype none
module ehash_mix (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63:0]              key,
   output ehash_pkg::mix_out_type   mix
);
   typedef enum logic [1:0] {MX_IDLE, MX_MUL, MX_DONE} mx_state_type;

   mx_state_type state_ff, state_in;
   logic [63:0] x_ff, x_in, acc_ff, acc_in, prod_ff, prod_in;
   logic [1:0]  step_ff, step_in;
   logic        pass_ff, pass_in;
   logic [ehash_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [31:0] op_a, op_b;
   logic [63:0] mult_c, sum, mixed;

   // low 64 bits of a 64x64 product from three 32x32 partials, one per cycle
   assign mult_c  = pass_ff ? ehash_pkg::MIX_C2 : ehash_pkg::MIX_C1;
   assign op_a    = (step_ff == 2'd1) ? x_ff[63:32] : x_ff[31:0];
   assign op_b    = (step_ff == 2'd2) ? mult_c[63:32] : mult_c[31:0];
   assign prod_in = op_a * op_b;
   assign sum     = acc_ff + {prod_ff[31:0], 32'd0};
   assign mixed   = sum ^ (sum >> ehash_pkg::MIX_SHIFT);

   assign mix.done = (state_ff == MX_DONE);
   assign mix.hash = hash_ff;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      pass_in  = pass_ff;
      hash_in  = hash_ff;
      unique case (state_ff)
         MX_IDLE: begin
            if (start) begin
               x_in     = key ^ (key >> ehash_pkg::MIX_SHIFT);
               step_in  = 2'd0;
               pass_in  = 1'b0;
               state_in = MX_MUL;
            end
         end
         MX_MUL: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1: acc_in = prod_ff;
               2'd2: acc_in = sum;
               2'd3: begin
                  x_in = mixed;
                  if (pass_ff) begin
                     hash_in  = mixed[ehash_pkg::HASH_W-1:0];
                     state_in = MX_DONE;
                  end else begin
                     pass_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         MX_DONE: state_in = MX_IDLE;
         default: state_in = MX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      pass_ff <= pass_in;
      hash_ff <= hash_in;
   end
endmodule
`default_nettype wire

FILE: src/extendible_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_type, req_key, req_rid_page, req_rid_slot
// rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_found_page, rsp_found_slot,
//                                            rsp_entry_count
// one request at a time: the key is hashed, then the directory and bucket metadata are read
// lookup and remove compare slots one by one; a remove shifts each later entry down, then
// writes the new fill; a split copies or remaps directory entries, rehashes each bucket
// entry to redistribute it, takes a new bucket, retries the insert and updates both buckets
// after reset the directory and bucket table seed entries 0 and 1
// the result register holds while rsp_stall is high; the next request may be taken
module extendible_hash_table_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic signed [63:0]  req_key,
   input  logic [31:0]         req_rid_page,
   input  logic [15:0]         req_rid_slot,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_found_page,
   output logic [15:0]         rsp_found_slot,
   output logic [12:0]         rsp_entry_count
);
   localparam int DIR_W   = ehash_pkg::DIR_W;
   localparam int BKT_W   = ehash_pkg::BKT_W;
   localparam int SLOT_W  = ehash_pkg::SLOT_W;
   localparam int FILL_W  = ehash_pkg::FILL_W;
   localparam int DEPTH_W = ehash_pkg::DEPTH_W;
   localparam int NFB_W   = ehash_pkg::NFB_W;
   localparam int SA_W    = ehash_pkg::SLOT_ADDR_W;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_HASH, S_DIRRD, S_META, S_DEC,
      S_SRD, S_SCHK, S_SHRD, S_SHWR, S_RMFIN,
      S_CPRD, S_CPWR, S_RMSET, S_RMRD, S_RMWR,
      S_RSRD, S_RSHS, S_RSWT, S_RETRY, S_MB, S_MN, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic                  init_ff, init_in;
   ehash_pkg::req_kind_type kind_ff, kind_in;
   logic [63:0]           key_ff, key_in;
   logic [31:0]           page_ff, page_in;
   logic [15:0]           rslot_ff, rslot_in;
   logic [ehash_pkg::HASH_W-1:0] hq_ff, hq_in;
   logic [BKT_W-1:0]      b_ff, b_in, nb_ff, nb_in;
   logic [DEPTH_W-1:0]    ld_ff, ld_in, gd_ff, gd_in;
   logic [FILL_W-1:0]     fill_ff, fill_in, i_ff, i_in, fb_ff, fb_in, fnb_ff, fnb_in;
   logic [NFB_W-1:0]      nfb_ff, nfb_in;
   logic [DIR_W:0]        ci_ff, ci_in;
   logic [12:0]           total_ff, total_in;
   ehash_pkg::entry_type  ent_ff, ent_in;
   ehash_pkg::status_type res_status_ff, res_status_in;
   logic [31:0]           res_page_ff, res_page_in;
   logic [15:0]           res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_page_ff, rsp_page_in;
   logic [15:0]           rsp_slot_ff, rsp_slot_in;
   logic [12:0]           rsp_count_ff, rsp_count_in;

   // memories
   logic [BKT_W-1:0]      dir_mem [ehash_pkg::DIR_ENTRIES];
   ehash_pkg::meta_type   meta_mem [ehash_pkg::DIR_ENTRIES];
   ehash_pkg::entry_type  slot_mem [ehash_pkg::SLOT_TOTAL];
   logic                  dir_we, meta_we, slot_we;
   logic [DIR_W-1:0]      dir_raddr, dir_waddr;
   logic [BKT_W-1:0]      dir_wdata, dir_rd_ff;
   logic [BKT_W-1:0]      meta_raddr, meta_waddr;
   ehash_pkg::meta_type   meta_wdata, meta_rd_ff;
   logic [SA_W-1:0]       slot_raddr, slot_waddr;
   ehash_pkg::entry_type  slot_wdata, slot_rd_ff;

   logic                  mix_start;
   logic [63:0]           mix_key;
   ehash_pkg::mix_out_type mix;

   logic [DIR_W:0]        dir_span;
   logic [DIR_W-1:0]      dir_mask;
   logic [FILL_W-1:0]     i_next;
   logic                  hq_bit, mix_bit, ci_bit;
   ehash_pkg::entry_type  req_entry;

   ehash_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (mix_key),
      .mix   (mix)
   );

   assign dir_span  = (DIR_W + 1)'(1) << gd_ff;
   assign dir_mask  = DIR_W'(dir_span - 1'b1);
   assign i_next    = i_ff + 1'b1;
   assign hq_bit    = |(hq_ff & (ehash_pkg::HASH_W'(1) << ld_ff));
   assign mix_bit   = |(mix.hash & (ehash_pkg::HASH_W'(1) << ld_ff));
   assign ci_bit    = |(ci_ff & ((DIR_W + 1)'(1) << ld_ff));
   assign req_entry = '{key: key_ff, page: page_ff, slot: rslot_ff};

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_page  = rsp_page_ff;
   assign rsp_found_slot  = rsp_slot_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      page_in       = page_ff;
      rslot_in      = rslot_ff;
      hq_in         = hq_ff;
      b_in          = b_ff;
      nb_in         = nb_ff;
      ld_in         = ld_ff;
      gd_in         = gd_ff;
      fill_in       = fill_ff;
      i_in          = i_ff;
      fb_in         = fb_ff;
      fnb_in        = fnb_ff;
      nfb_in        = nfb_ff;
      ci_in         = ci_ff;
      total_in      = total_ff;
      ent_in        = ent_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      dir_we        = 1'b0;
      dir_raddr     = '0;
      dir_waddr     = '0;
      dir_wdata     = '0;
      meta_we       = 1'b0;
      meta_raddr    = '0;
      meta_waddr    = '0;
      meta_wdata    = '0;
      slot_we       = 1'b0;
      slot_raddr    = '0;
      slot_waddr    = '0;
      slot_wdata    = req_entry;
      mix_start     = 1'b0;
      mix_key       = key_ff;

      unique case (state_ff)
         S_INIT: begin
            // directory entries 0 and 1 point at buckets 0 and 1 of depth one
            dir_we     = 1'b1;
            dir_waddr  = DIR_W'(init_ff);
            dir_wdata  = BKT_W'(init_ff);
            meta_we    = 1'b1;
            meta_waddr = BKT_W'(init_ff);
            meta_wdata = '{ld: DEPTH_W'(1), fill: '0};
            init_in    = 1'b1;
            if (init_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = ehash_pkg::req_kind_type'(req_type);
               key_in        = req_key;
               page_in       = req_rid_page;
               rslot_in      = req_rid_slot;
               res_status_in = ehash_pkg::STS_NOT_FOUND;
               res_page_in   = '0;
               res_slot_in   = '0;
               if (req_type == ehash_pkg::REQ_UNKNOWN) begin
                  state_in = S_FIN;
               end else begin
                  mix_start = 1'b1;
                  mix_key   = req_key;
                  state_in  = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (mix.done) begin
               hq_in    = mix.hash;
               state_in = S_DIRRD;
            end
         end
         S_DIRRD: begin
            dir_raddr = hq_ff[DIR_W-1:0] & dir_mask;
            state_in  = S_META;
         end
         S_META: begin
            b_in       = dir_rd_ff;
            meta_raddr = dir_rd_ff;
            state_in   = S_DEC;
         end
         S_DEC: begin
            ld_in   = meta_rd_ff.ld;
            fill_in = meta_rd_ff.fill;
            i_in    = '0;
            if (kind_ff == ehash_pkg::REQ_INSERT) begin
               if (meta_rd_ff.fill < FILL_W'(ehash_pkg::BUCKET_SLOTS)) begin
                  slot_we       = 1'b1;
                  slot_waddr    = {b_ff, meta_rd_ff.fill[SLOT_W-1:0]};
                  meta_we       = 1'b1;
                  meta_waddr    = b_ff;
                  meta_wdata    = '{ld: meta_rd_ff.ld, fill: meta_rd_ff.fill + 1'b1};
                  total_in      = total_ff + 1'b1;
                  res_status_in = ehash_pkg::STS_OK;
                  state_in      = S_FIN;
               end else if (meta_rd_ff.ld >= gd_ff) begin
                  if (gd_ff == DEPTH_W'(ehash_pkg::MAX_GLOBAL_DEPTH) || nfb_ff[NFB_W-1]) begin
                     res_status_in = ehash_pkg::STS_FULL;
                     state_in      = S_FIN;
                  end else begin
                     ci_in    = '0;
                     state_in = S_CPRD;
                  end
               end else if (nfb_ff[NFB_W-1]) begin
                  res_status_in = ehash_pkg::STS_FULL;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_RMSET;
               end
            end else if (meta_rd_ff.fill == '0) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            slot_raddr = {b_ff, i_ff[SLOT_W-1:0]};
            state_in   = S_SCHK;
         end
         S_SCHK: begin
            if (slot_rd_ff.key == key_ff) begin
               res_status_in = ehash_pkg::STS_OK;
               res_page_in   = slot_rd_ff.page;
               res_slot_in   = slot_rd_ff.slot;
               if (kind_ff == ehash_pkg::REQ_REMOVE) begin
                  state_in = (i_next < fill_ff) ? S_SHRD : S_RMFIN;
               end else begin
                  state_in = S_FIN;
               end
            end else if (i_next < fill_ff) begin
               i_in     = i_next;
               state_in = S_SRD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SHRD: begin
            slot_raddr = {b_ff, i_next[SLOT_W-1:0]};
            state_in   = S_SHWR;
         end
         S_SHWR: begin
            // move the later entry down over the removed one
            slot_we    = 1'b1;
            slot_waddr = {b_ff, i_ff[SLOT_W-1:0]};
            slot_wdata = slot_rd_ff;
            i_in       = i_next;
            state_in   = ((i_next + 1'b1) < fill_ff) ? S_SHRD : S_RMFIN;
         end
         S_RMFIN: begin
            meta_we    = 1'b1;
            meta_waddr = b_ff;
            meta_wdata = '{ld: ld_ff, fill: fill_ff - 1'b1};
            total_in   = total_ff - 1'b1;
            state_in   = S_FIN;
         end
         S_CPRD: begin
            dir_raddr = ci_ff[DIR_W-1:0];
            state_in  = S_CPWR;
         end
         S_CPWR: begin
            // upper half of the doubled directory mirrors the lower half
            dir_we    = 1'b1;
            dir_waddr = DIR_W'(ci_ff + dir_span);
            dir_wdata = dir_rd_ff;
            ci_in     = ci_ff + 1'b1;
            if ((ci_ff + 1'b1) == dir_span) begin
               gd_in    = gd_ff + 1'b1;
               state_in = S_RMSET;
            end else begin
               state_in = S_CPRD;
            end
         end
         S_RMSET: begin
            nb_in    = nfb_ff[BKT_W-1:0];
            nfb_in   = nfb_ff + 1'b1;
            ci_in    = '0;
            state_in = S_RMRD;
         end
         S_RMRD: begin
            dir_raddr = ci_ff[DIR_W-1:0];
            state_in  = S_RMWR;
         end
         S_RMWR: begin
            if (dir_rd_ff == b_ff && ci_bit) begin
               dir_we    = 1'b1;
               dir_waddr = ci_ff[DIR_W-1:0];
               dir_wdata = nb_ff;
            end
            ci_in = ci_ff + 1'b1;
            if ((ci_ff + 1'b1) == dir_span) begin
               i_in     = '0;
               fb_in    = '0;
               fnb_in   = '0;
               state_in = S_RSRD;
            end else begin
               state_in = S_RMRD;
            end
         end
         S_RSRD: begin
            slot_raddr = {b_ff, i_ff[SLOT_W-1:0]};
            state_in   = S_RSHS;
         end
         S_RSHS: begin
            ent_in    = slot_rd_ff;
            mix_start = 1'b1;
            mix_key   = slot_rd_ff.key;
            state_in  = S_RSWT;
         end
         S_RSWT: begin
            // in-place redistribution: write position never passes read position
            if (mix.done) begin
               slot_we    = 1'b1;
               slot_wdata = ent_ff;
               if (mix_bit) begin
                  slot_waddr = {nb_ff, fnb_ff[SLOT_W-1:0]};
                  fnb_in     = fnb_ff + 1'b1;
               end else begin
                  slot_waddr = {b_ff, fb_ff[SLOT_W-1:0]};
                  fb_in      = fb_ff + 1'b1;
               end
               i_in     = i_next;
               state_in = (i_next == fill_ff) ? S_RETRY : S_RSRD;
            end
         end
         S_RETRY: begin
            res_status_in = ehash_pkg::STS_FULL;
            if (hq_bit) begin
               if (fnb_ff < FILL_W'(ehash_pkg::BUCKET_SLOTS)) begin
                  slot_we       = 1'b1;
                  slot_waddr    = {nb_ff, fnb_ff[SLOT_W-1:0]};
                  fnb_in        = fnb_ff + 1'b1;
                  total_in      = total_ff + 1'b1;
                  res_status_in = ehash_pkg::STS_OK;
               end
            end else if (fb_ff < FILL_W'(ehash_pkg::BUCKET_SLOTS)) begin
               slot_we       = 1'b1;
               slot_waddr    = {b_ff, fb_ff[SLOT_W-1:0]};
               fb_in         = fb_ff + 1'b1;
               total_in      = total_ff + 1'b1;
               res_status_in = ehash_pkg::STS_OK;
            end
            state_in = S_MB;
         end
         S_MB: begin
            meta_we    = 1'b1;
            meta_waddr = b_ff;
            meta_wdata = '{ld: ld_ff + 1'b1, fill: fb_ff};
            state_in   = S_MN;
         end
         S_MN: begin
            meta_we    = 1'b1;
            meta_waddr = nb_ff;
            meta_wdata = '{ld: ld_ff + 1'b1, fill: fnb_ff};
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_page_in   = res_page_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_count_in  = total_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= 1'b0;
         gd_ff        <= DEPTH_W'(1);
         nfb_ff       <= NFB_W'(2);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         gd_ff        <= gd_in;
         nfb_ff       <= nfb_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      page_ff       <= page_in;
      rslot_ff      <= rslot_in;
      hq_ff         <= hq_in;
      b_ff          <= b_in;
      nb_ff         <= nb_in;
      ld_ff         <= ld_in;
      fill_ff       <= fill_in;
      i_ff          <= i_in;
      fb_ff         <= fb_in;
      fnb_ff        <= fnb_in;
      ci_ff         <= ci_in;
      ent_ff        <= ent_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
      dir_rd_ff <= dir_mem[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_raddr];
   end
endmodule
`default_nettype wire

FILE: src/ehash_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ehash_check (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic [31:0]         rsp_found_page,
   input logic [15:0]         rsp_found_slot,
   input logic [12:0]         rsp_entry_count
);
   // a request is worked on alone, so intake closes right after acceptance
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall)
   // a result other than OK (not found or full) carries a zero record id
   `ASSERT_NOW(a_zero_rid, clock, reset, rsp_valid && rsp_status != 2'd0,
      rsp_found_page == 32'd0 && rsp_found_slot == 16'd0)
   // the table never holds more entries than it has slots
   `ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_entry_count <= 13'd4096)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_entry_count) && $stable(rsp_status))
endmodule

bind extendible_hash_table_core ehash_check u_ehash_check (.*);
`default_nettype wire
